>>> rtl/tefs_pkg.sv
// Shared types and constants for the timed event queue.
`timescale 1ns / 1ps
package tefs_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DUE_W         = 64;
    localparam int TAG_W         = 8;
    localparam int TICK_W        = 32;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 3;

    // request opcodes; the reserved code is ignored
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH     = 2'd0,
        ACT_ADVANCE  = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_RESERVED = 2'd3
    } action_t;

    // result codes
    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FIRED    = 3'd2,
        ST_IDLE     = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    // one queued event
    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [TAG_W-1:0] tag;
    } cell_data_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic pop;
        logic load;
    } cell_ctrl_t;

endpackage

>>> rtl/tefs_req_if.sv
// Request channel: valid/ready handshake with the event command payload.
`timescale 1ns / 1ps
interface tefs_req_if
    import tefs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DUE_W-1:0]  due_time;
    logic [TAG_W-1:0]  event_tag;
    logic [TICK_W-1:0] tick_cycles;

    modport source (output valid, action, due_time, event_tag, tick_cycles, input ready);
    modport sink   (input valid, action, due_time, event_tag, tick_cycles, output ready);
endinterface

>>> rtl/tefs_rsp_if.sv
// Result channel: valid/ready handshake with the status payload.
`timescale 1ns / 1ps
interface tefs_rsp_if
    import tefs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  fired_tag;
    logic              last;

    modport source (output valid, status, fired_tag, last, input ready);
    modport sink   (input valid, status, fired_tag, last, output ready);
endinterface

>>> rtl/tefs_cell.sv
// One queue slot: takes its neighbor's event on a pop, the new event on a load.
`timescale 1ns / 1ps
module tefs_cell
    import tefs_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  cell_data_t push_data,
    input  cell_data_t neighbor,
    output cell_data_t data
);

    cell_data_t data_reg;
    cell_data_t data_next;

    // shift toward the head on a pop, capture at the tail on a push
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.pop)
        begin
            data_next = neighbor;
        end
        else if (ctrl.load)
        begin
            data_next = push_data;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/timed_event_fifo_scheduler_unit.sv
// Top level of the timed event queue: sequencer, time counter and cell chain.
//
//  channel | dir | payload                                      | transaction
//  --------+-----+----------------------------------------------+--------------------
//  req     | in  | action, due_time, event_tag, tick_cycles     | valid & ready
//  rsp     | out | status, fired_tag, last                      | valid & ready
//
//  Push, clear: the result is registered in the cycle after the request is taken.
//  Advance: the time updates as the request is taken, then one fired event per cycle (or
//  one nothing-due result); the head compare on the cell chain sets this pace.
//  rsp is registered; a stalled rsp holds the sequencer, req waits in idle state.
//  rst_n clears time, count, sequencer and result valid; cells keep no reset.
`timescale 1ns / 1ps
module timed_event_fifo_scheduler_unit
    import tefs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    tefs_req_if.sink   req,
    tefs_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // sequencer and counters
    state_t            state_reg;
    state_t            state_next;
    logic [DUE_W-1:0]  now_time_reg;
    logic [DUE_W-1:0]  now_time_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    // result register
    logic              ovalid_reg;
    logic              ovalid_next;
    status_t           ostatus_reg;
    status_t           ostatus_next;
    logic [TAG_W-1:0]  otag_reg;
    logic [TAG_W-1:0]  otag_next;
    logic              olast_reg;
    logic              olast_next;

    // sequencer outputs
    logic              out_free;
    logic              accept;
    logic              emit;
    status_t           emit_status;
    logic [TAG_W-1:0]  emit_tag;
    logic              emit_last;
    logic              do_pop;
    logic              do_push;
    logic              do_clear;
    logic              do_advance;

    // chain signals
    cell_data_t        chain [DEPTH];
    cell_data_t        push_data;
    logic              full;
    logic              head_due;
    logic              next_due;
    logic              fire;
    logic              more;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign push_data = '{due: req.due_time, tag: req.event_tag};

    // head and lookahead compares against the current time
    assign head_due = (now_time_reg >= chain[0].due);
    assign next_due = (now_time_reg >= chain[1].due);
    assign fire     = (count_reg != '0) && head_due;
    assign more     = (count_reg > CW'(1)) && next_due;

    // cell chain, head at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        cell_data_t neighbor;

        assign ctrl.pop  = do_pop;
        assign ctrl.load = do_push && (count_reg == CW'(i));

        if (i < DEPTH - 1)
        begin : g_mid
            assign neighbor = chain[i + 1];
        end
        else
        begin : g_tail
            assign neighbor = push_data;
        end

        tefs_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .push_data (push_data),
            .neighbor  (neighbor),
            .data      (chain[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action_t'(req.action) == ACT_ADVANCE))
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (out_free && !(fire && more))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready   = 1'b0;
        emit        = 1'b0;
        emit_status = ST_IDLE;
        emit_tag    = '0;
        emit_last   = 1'b1;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        do_clear    = 1'b0;
        do_advance  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = out_free;
                if (accept)
                begin
                    unique case (action_t'(req.action))
                        ACT_PUSH:
                        begin
                            emit        = 1'b1;
                            do_push     = !full;
                            emit_status = full ? ST_FULL : ST_ACCEPTED;
                        end
                        ACT_ADVANCE:  do_advance = 1'b1;
                        ACT_CLEAR:
                        begin
                            emit        = 1'b1;
                            do_clear    = 1'b1;
                            emit_status = ST_CLEARED;
                        end
                        ACT_RESERVED: ;
                        default: ;
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (fire)
                    begin
                        do_pop      = 1'b1;
                        emit_status = ST_FIRED;
                        emit_tag    = chain[0].tag;
                        emit_last   = !more;
                    end
                end
            end
            default: ;
        endcase
    end

    // time, count and result register next values
    always_comb
    begin
        now_time_next = now_time_reg;
        if (do_advance)
        begin
            now_time_next = now_time_reg + DUE_W'(req.tick_cycles);
        end

        count_next = count_reg;
        priority if (do_clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end

        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        otag_next    = otag_reg;
        olast_next   = olast_reg;
        if (emit)
        begin
            ovalid_next  = 1'b1;
            ostatus_next = emit_status;
            otag_next    = emit_tag;
            olast_next   = emit_last;
        end
        else if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            now_time_reg <= '0;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            now_time_reg <= now_time_next;
            count_reg    <= count_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        ostatus_reg <= ostatus_next;
        otag_reg    <= otag_next;
        olast_reg   <= olast_next;
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = ostatus_reg;
    assign rsp.fired_tag = otag_reg;
    assign rsp.last      = olast_reg;

    // occupancy never goes past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // a fired event leaves the queue
    a_fire_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP && out_free && fire) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("fired event not removed");

    // a fired result only comes from a non-empty queue with a due head
    a_fired_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_status == ST_FIRED) |-> (count_reg != '0) && head_due)
        else $error("fired result without a due head");

    // the time only moves on an accepted advance
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && (action_t'(req.action) == ACT_ADVANCE)) |=> $stable(now_time_reg))
        else $error("time changed without an advance");

    // requests are only taken while the sequencer is idle
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !accept && !do_push && !do_clear)
        else $error("request taken while popping");

endmodule

>>> bench/timed_event_fifo_scheduler_unit_tb.sv
// Self-checking bench for the timed event queue: directed and random request traffic, predicted results.
`timescale 1ns / 1ps
module timed_event_fifo_scheduler_unit_tb;
    import tefs_pkg::*;

    localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 72;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PRINT_LIMIT   = 20;

    // one request transaction plus the idle cycles that follow it
    typedef struct packed {
        action_t           action;
        logic [DUE_W-1:0]  due;
        logic [TAG_W-1:0]  tag;
        logic [TICK_W-1:0] tick;
        logic [2:0]        gap;
    } sched_req_t;

    // one result transaction as it should appear
    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic             last;
    } sched_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tefs_req_if req_ch ();
    tefs_rsp_if rsp_ch ();

    timed_event_fifo_scheduler_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // driven copies of the block inputs, known from time zero
    logic       drv_valid = 1'b0;
    sched_req_t drv_item  = '0;
    logic       rcv_ready = 1'b0;

    assign req_ch.valid       = drv_valid;
    assign req_ch.action      = drv_item.action;
    assign req_ch.due_time    = drv_item.due;
    assign req_ch.event_tag   = drv_item.tag;
    assign req_ch.tick_cycles = drv_item.tick;
    assign rsp_ch.ready       = rcv_ready;

    // stimulus and prediction state
    sched_req_t        stim_q[$];
    sched_rsp_t        awaited_results[$];
    cell_data_t        model_events[$];
    logic [DUE_W-1:0]  model_now;
    logic [DUE_W-1:0]  gen_now;
    logic              gen_quiet;

    int   err_count   = 0;
    int   cycle_count = 0;
    int   rsp_count   = 0;
    int   hold_left   = 0;
    logic hold_armed  = 1'b1;

    int n_push     = 0;
    int n_dropped  = 0;
    int n_advance  = 0;
    int n_fired    = 0;
    int n_clear    = 0;
    int n_ignored  = 0;
    int max_burst  = 0;

    int         drv_wait;
    logic       drv_next;
    sched_req_t drv_pick;
    int         rcv_wait;
    logic       rcv_next;
    sched_rsp_t want;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic await_result(input status_t st, input logic [TAG_W-1:0] tg, input logic lst);
        sched_rsp_t r;
        r.status = st;
        r.tag    = tg;
        r.last   = lst;
        awaited_results.push_back(r);
    endtask

    // queue model: update time and events, record the results this request causes
    task automatic apply_request(input sched_req_t it);
        int         fired;
        cell_data_t evt;
        fired = 0;
        case (it.action)
            ACT_PUSH:
            begin
                if (model_events.size() < QUEUE_DEPTH)
                begin
                    evt.due = it.due;
                    evt.tag = it.tag;
                    model_events.push_back(evt);
                    await_result(ST_ACCEPTED, '0, 1'b1);
                    n_push++;
                end
                else
                begin
                    await_result(ST_FULL, '0, 1'b1);
                    n_dropped++;
                end
            end
            ACT_ADVANCE:
            begin
                model_now = model_now + DUE_W'(it.tick);
                while (model_events.size() != 0 && fired < QUEUE_DEPTH &&
                       model_now >= model_events[0].due)
                begin
                    await_result(ST_FIRED, model_events[0].tag, 1'b0);
                    void'(model_events.pop_front());
                    fired++;
                end
                if (fired == 0)
                    await_result(ST_IDLE, '0, 1'b1);
                else
                    awaited_results[awaited_results.size()-1].last = 1'b1;
                n_advance++;
                n_fired += fired;
                if (fired > max_burst)
                    max_burst = fired;
            end
            ACT_CLEAR:
            begin
                model_events.delete();
                await_result(ST_CLEARED, '0, 1'b1);
                n_clear++;
            end
            default:
                n_ignored++;
        endcase
    endtask

    // append a request; the generator tracks time so due times land near it
    task automatic queue_request(input action_t a, input logic [DUE_W-1:0] d,
                                 input logic [TAG_W-1:0] t, input logic [TICK_W-1:0] c);
        sched_req_t it;
        it.action = a;
        it.due    = d;
        it.tag    = t;
        it.tick   = c;
        it.gap    = gen_quiet ? 3'd0 : 3'($urandom_range(0, 4));
        stim_q.push_back(it);
        if (a == ACT_ADVANCE)
            gen_now = gen_now + DUE_W'(c);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_item  <= '0;
            drv_wait  = 0;
            model_now = '0;
            model_events.delete();
        end
        else
        begin
            drv_next = drv_valid;
            if (drv_valid && req_ch.ready)
            begin
                apply_request(drv_item);
                drv_next = 1'b0;
            end
            if (!drv_next)
            begin
                if (drv_wait > 0)
                    drv_wait--;
                else if (stim_q.size() != 0)
                begin
                    drv_pick = stim_q.pop_front();
                    drv_item <= drv_pick;
                    drv_next = 1'b1;
                    drv_wait = drv_pick.gap;
                end
            end
            drv_valid <= drv_next;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
            rsp_count <= 0;
            rcv_wait  = 0;
        end
        else
        begin
            if (rsp_ch.valid && rcv_ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("unexpected result status=%0d tag=%0h last=%0b",
                                              rsp_ch.status, rsp_ch.fired_tag, rsp_ch.last));
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.fired_tag !== want.tag)
                        report_mismatch($sformatf("fired_tag %0h, expected %0h",
                                                  rsp_ch.fired_tag, want.tag));
                    if (rsp_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  rsp_ch.last, want.last));
                end
                rsp_count <= rsp_count + 1;
                // every third stretch of 25 results runs without random stalls
                rcv_wait = ((rsp_count / 25) % 3 == 1) ? 0 : $urandom_range(0, 4);
            end
            if (rcv_wait > 0)
            begin
                rcv_wait--;
                rcv_next = 1'b0;
            end
            else
                rcv_next = 1'b1;
            if (hold_left != 0)
                rcv_next = 1'b0;
            rcv_ready <= rcv_next;
        end
    end

    // one long receiver hold-off so the block backs up into the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && rsp_count == HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[timed_event_fifo_scheduler_unit] ERROR");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int               i;
        int               j;
        int               k;
        int               r;
        logic [DUE_W-1:0] d;
        logic [TICK_W-1:0] c;

        gen_now   = '0;
        gen_quiet = 1'b0;

        // directed: empty queue, ignored code, field extremes
        queue_request(ACT_ADVANCE, '0, '0, '0);
        queue_request(ACT_RESERVED, '1, '1, '1);
        queue_request(ACT_PUSH, '0, 8'h00, '0);
        queue_request(ACT_PUSH, '1, 8'hFF, '0);
        queue_request(ACT_PUSH, 64'd5, 8'hA5, '0);
        // due-at-zero head fires, then the far head blocks a later due event
        queue_request(ACT_ADVANCE, '0, '0, '0);
        queue_request(ACT_ADVANCE, '0, '0, 32'hFFFF_FFFF);
        queue_request(ACT_CLEAR, '0, '0, '0);
        queue_request(ACT_ADVANCE, '0, '0, 32'd1);
        // a burst of three in order, then an event due exactly at the new time
        queue_request(ACT_PUSH, gen_now, 8'h01, '0);
        queue_request(ACT_PUSH, gen_now + 64'd1, 8'h02, '0);
        queue_request(ACT_PUSH, gen_now + 64'd2, 8'h03, '0);
        queue_request(ACT_PUSH, gen_now + 64'd100, 8'h04, '0);
        queue_request(ACT_ADVANCE, '0, '0, 32'd2);
        queue_request(ACT_ADVANCE, '0, '0, 32'd98);
        // alternating bit patterns
        queue_request(ACT_PUSH, 64'h5555_5555_5555_5555, 8'h55, 32'h5555_5555);
        queue_request(ACT_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 32'hAAAA_AAAA);
        queue_request(ACT_ADVANCE, '0, '0, 32'hAAAA_AAAA);
        queue_request(ACT_ADVANCE, '0, '0, 32'h5555_5555);
        queue_request(ACT_CLEAR, '1, '1, '1);
        queue_request(ACT_RESERVED, '0, '0, '0);

        // random traffic, mostly due times near the running time
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 20 == 0)
                gen_quiet = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
            begin
                // fill past capacity, then release the whole queue in one advance
                queue_request(ACT_CLEAR, '0, '0, '0);
                for (j = 0; j < QUEUE_DEPTH + 2; j++)
                    queue_request(ACT_PUSH, gen_now + 64'($urandom_range(0, 400)),
                                  8'($urandom_range(0, 255)), '0);
                queue_request(ACT_ADVANCE, '0, '0, 32'hFFFF_FFFF);
            end
            k = $urandom_range(0, 99);
            if (k < 55)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    d = {$urandom, $urandom};
                else if (r < 3)
                    d = gen_now;
                else if (r < 6 && gen_now > 64'd50)
                    d = gen_now - 64'($urandom_range(1, 50));
                else
                    d = gen_now + 64'($urandom_range(1, 3000));
                queue_request(ACT_PUSH, d, 8'($urandom_range(0, 255)), $urandom);
            end
            else if (k < 88)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    c = $urandom;
                else if (r == 1)
                    c = '0;
                else
                    c = 32'($urandom_range(1, 1500));
                queue_request(ACT_ADVANCE, {$urandom, $urandom}, 8'($urandom_range(0, 255)), c);
            end
            else if (k < 94)
                queue_request(ACT_CLEAR, {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                              $urandom);
            else
                queue_request(ACT_RESERVED, {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                              $urandom);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || drv_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d pushes, %0d dropped on full, %0d clears, %0d ignored codes",
                 n_push, n_dropped, n_clear, n_ignored);
        $display("and %0d advances firing %0d events (largest burst %0d), %0d results checked",
                 n_advance, n_fired, max_burst, rsp_count);
        if (err_count == 0)
            $display("[timed_event_fifo_scheduler_unit] OK");
        else
            $display("[timed_event_fifo_scheduler_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/tefs_pkg.sv
rtl/tefs_req_if.sv
rtl/tefs_rsp_if.sv
rtl/tefs_cell.sv
rtl/timed_event_fifo_scheduler_unit.sv
bench/timed_event_fifo_scheduler_unit_tb.sv
